@@ rtl/core/ntm_pkg.sv @@
package ntm_pkg;

  localparam int SAMPLE_BITS       = 16;
  localparam int ENTRY_W           = 6;
  localparam int POS_W             = 5;
  localparam int DIST_W            = 37;
  localparam int CFG_W             = 7;
  localparam int MAX_ENTRIES_DEF   = 64;
  localparam int SIGNAL_LENGTH_DEF = 20;
  localparam int QUEUE_DEPTH       = 4;
  localparam int S_DATA_W          = 32;
  localparam int M_DATA_W          = 48;
  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;

  localparam logic             REG_ENTRIES_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] CFG_RESET          = 7'd1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_MATCH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                kind;
    logic [ENTRY_W-1:0]       entry;
    logic [POS_W-1:0]         position;
    logic [SAMPLE_BITS-1:0]   sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } back_state_e;

endpackage

@@ rtl/core/ntm_front.sv @@
module ntm_front #(
  parameter int MAX_ENTRIES   = ntm_pkg::MAX_ENTRIES_DEF,
  parameter int SIGNAL_LENGTH = ntm_pkg::SIGNAL_LENGTH_DEF
) (
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ntm_pkg::S_DATA_W-1:0]        s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  ntm_pkg::queue_stat_t                queue_stat_i,
  output logic                                push_o,
  output ntm_pkg::cmd_t                       cmd_o
);

  logic [ntm_pkg::ENTRY_W-1:0]     entry;
  logic [ntm_pkg::POS_W-1:0]       position;
  logic [ntm_pkg::SAMPLE_BITS-1:0] sample;
  logic                            pos_ok;
  logic                            entry_ok;
  logic                            keep;

  assign entry    = s_axis_tdata[ntm_pkg::ENTRY_W-1:0];
  assign position = s_axis_tdata[ntm_pkg::ENTRY_W+ntm_pkg::POS_W-1:ntm_pkg::ENTRY_W];
  assign sample   = s_axis_tdata[ntm_pkg::ENTRY_W+ntm_pkg::POS_W+ntm_pkg::SAMPLE_BITS-1:
                                 ntm_pkg::ENTRY_W+ntm_pkg::POS_W];

  assign pos_ok   = 32'(position) < SIGNAL_LENGTH;
  assign entry_ok = 32'(entry) < MAX_ENTRIES;

  always_comb begin
    cmd_o.entry    = entry;
    cmd_o.position = position;
    cmd_o.sample   = sample;
    if (s_axis_tuser == ntm_pkg::FUNC_LOAD) begin
      cmd_o.kind = ntm_pkg::CMD_LOAD;
      keep       = pos_ok && entry_ok;
    end else if (32'(position) == SIGNAL_LENGTH - 1) begin
      cmd_o.kind = ntm_pkg::CMD_MATCH;
      keep       = 1'b1;
    end else begin
      cmd_o.kind = ntm_pkg::CMD_QUERY;
      keep       = pos_ok;
    end
  end

  assign s_axis_tready = !queue_stat_i.full;
  assign push_o        = s_axis_tvalid && s_axis_tready && keep;

endmodule

@@ rtl/core/ntm_cmd_queue.sv @@
module ntm_cmd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ntm_pkg::cmd_t        cmd_i,
  input  logic                 pop_i,
  output ntm_pkg::cmd_t        head_o,
  output ntm_pkg::queue_stat_t stat_o
);

  localparam int PTR_W = $clog2(ntm_pkg::QUEUE_DEPTH);

  ntm_pkg::cmd_t    slot_q [ntm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = count_q == (PTR_W+1)'(ntm_pkg::QUEUE_DEPTH);
  assign stat_o.empty = count_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/core/ntm_back.sv @@
module ntm_back #(
  parameter int MAX_ENTRIES   = ntm_pkg::MAX_ENTRIES_DEF,
  parameter int SIGNAL_LENGTH = ntm_pkg::SIGNAL_LENGTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ntm_pkg::CFG_W-1:0]     entries_in_use_i,
  input  logic                          head_valid_i,
  input  ntm_pkg::cmd_t                 head_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ntm_pkg::M_DATA_W-1:0]  m_axis_tdata
);

  localparam int SB    = ntm_pkg::SAMPLE_BITS;
  localparam int EW    = $clog2(MAX_ENTRIES);
  localparam int DEPTH = MAX_ENTRIES * SIGNAL_LENGTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (SIGNAL_LENGTH > 1) ? $clog2(SIGNAL_LENGTH) : 1;
  localparam int ACC_W = 2 * SB + $clog2(SIGNAL_LENGTH);
  localparam logic [PW-1:0] K_LAST = PW'(SIGNAL_LENGTH - 1);

  ntm_pkg::back_state_e state_q, state_d;

  logic [SB-1:0] tmpl_mem [DEPTH];
  logic [SB-1:0] qbuf_q [SIGNAL_LENGTH];

  logic [EW-1:0] last_entry;
  logic [EW-1:0] e_q;
  logic [PW-1:0] k_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] wr_addr;

  logic          mem_we;
  logic          qbuf_we;
  logic          start;
  logic          issue;
  logic          out_load;

  logic          v1_q, first1_q, last1_q;
  logic [EW-1:0] ent1_q;
  logic [SB-1:0] t1_q, q1_q;

  logic              v2_q, first2_q, last2_q;
  logic [EW-1:0]     ent2_q;
  logic signed [SB:0] diff2_q;
  logic signed [SB:0] diff_d;

  logic            v3_q, first3_q, last3_q;
  logic [EW-1:0]   ent3_q;
  logic [2*SB-1:0] sq3_q;
  logic signed [2*SB+1:0] prod;

  logic             done4_q;
  logic [EW-1:0]    ent4_q;
  logic [ACC_W-1:0] acc_q;

  logic [ACC_W-1:0] best_q;
  logic [EW-1:0]    best_idx_q;
  logic             pipe_busy;

  logic                        out_valid_q;
  logic [ntm_pkg::ENTRY_W-1:0] out_entry_q;
  logic [ntm_pkg::DIST_W-1:0]  out_dist_q;

  always_comb begin
    if (entries_in_use_i == '0) begin
      last_entry = '0;
    end else if (32'(entries_in_use_i) > MAX_ENTRIES) begin
      last_entry = EW'(MAX_ENTRIES - 1);
    end else begin
      last_entry = EW'(entries_in_use_i - 1'b1);
    end
  end

  assign wr_addr   = AW'(32'(head_i.entry) * SIGNAL_LENGTH + 32'(head_i.position));
  assign pipe_busy = v1_q || v2_q || v3_q || done4_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ntm_pkg::ST_IDLE: begin
        if (head_valid_i && head_i.kind == ntm_pkg::CMD_MATCH) begin
          state_d = ntm_pkg::ST_SCAN;
        end
      end
      ntm_pkg::ST_SCAN: begin
        if (e_q == last_entry && k_q == K_LAST) begin
          state_d = ntm_pkg::ST_DRAIN;
        end
      end
      ntm_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = ntm_pkg::ST_REPORT;
        end
      end
      ntm_pkg::ST_REPORT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ntm_pkg::ST_IDLE;
        end
      end
      default: state_d = ntm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    qbuf_we  = 1'b0;
    start    = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ntm_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          case (head_i.kind)
            ntm_pkg::CMD_LOAD: mem_we = 1'b1;
            ntm_pkg::CMD_MATCH: begin
              qbuf_we = 1'b1;
              start   = 1'b1;
            end
            default: qbuf_we = 1'b1;
          endcase
        end
      end
      ntm_pkg::ST_SCAN:   issue = 1'b1;
      ntm_pkg::ST_DRAIN:  ;
      ntm_pkg::ST_REPORT: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntm_pkg::ST_IDLE;
      e_q     <= '0;
      k_q     <= '0;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        e_q    <= '0;
        k_q    <= '0;
        addr_q <= '0;
      end else if (issue) begin
        addr_q <= addr_q + 1'b1;
        if (k_q == K_LAST) begin
          k_q <= '0;
          e_q <= e_q + 1'b1;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tmpl_mem[wr_addr] <= head_i.sample;
    end
    t1_q <= tmpl_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (qbuf_we) begin
      qbuf_q[PW'(head_i.position)] <= head_i.sample;
    end
    q1_q <= qbuf_q[k_q];
  end

  assign diff_d = $signed({q1_q[SB-1], q1_q}) - $signed({t1_q[SB-1], t1_q});
  assign prod   = diff2_q * diff2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      done4_q <= 1'b0;
    end else begin
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      done4_q <= v3_q && last3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    first1_q <= k_q == '0;
    last1_q  <= k_q == K_LAST;
    ent1_q   <= e_q;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    ent2_q   <= ent1_q;
    diff2_q  <= diff_d;
    first3_q <= first2_q;
    last3_q  <= last2_q;
    ent3_q   <= ent2_q;
    sq3_q    <= prod[2*SB-1:0];
    ent4_q   <= ent3_q;
    if (v3_q) begin
      acc_q <= first3_q ? ACC_W'(sq3_q) : acc_q + ACC_W'(sq3_q);
    end
    if (done4_q && (ent4_q == '0 || acc_q < best_q)) begin
      best_q     <= acc_q;
      best_idx_q <= ent4_q;
    end
    if (out_load) begin
      out_entry_q <= ntm_pkg::ENTRY_W'(best_idx_q);
      out_dist_q  <= ntm_pkg::DIST_W'(best_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ntm_pkg::M_DATA_W'({out_dist_q, out_entry_q});

endmodule

@@ rtl/core/nearest_template_match.sv @@
// Load and query beats are taken at one per cycle, while the queue is not full, through a four-deep command queue.
// A query beat at the last position starts a match that reads the template memory
// once per sample, then drains the pipeline and reports the result.
// While a match runs, up to four further beats are queued before s_axis_tready falls.
// rst_ni is asynchronous and active low; it clears control state and entries_in_use
// to one. Template and query samples are undefined until written.
module nearest_template_match #(
  parameter int MAX_ENTRIES   = ntm_pkg::MAX_ENTRIES_DEF,
  parameter int SIGNAL_LENGTH = ntm_pkg::SIGNAL_LENGTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry [5:0], position [10:6], sample_value [26:11], zero padding above
  input  logic [ntm_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // func
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // best_entry [5:0], min_distance [42:6], zero padding above
  output logic [ntm_pkg::M_DATA_W-1:0]      m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ntm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ntm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ntm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [ntm_pkg::CFG_W-1:0] entries_q;
  logic                      reg_hit;
  ntm_pkg::queue_stat_t      queue_stat;
  ntm_pkg::cmd_t             push_cmd;
  ntm_pkg::cmd_t             head_cmd;
  logic                      push;
  logic                      pop;

  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == ntm_pkg::REG_ENTRIES_IN_USE;
  assign prdata  = reg_hit ? ntm_pkg::APB_DATA_W'(entries_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= ntm_pkg::CFG_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      entries_q <= pwdata[ntm_pkg::CFG_W-1:0];
    end
  end

  ntm_front #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .SIGNAL_LENGTH(SIGNAL_LENGTH)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .queue_stat_i (queue_stat),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ntm_cmd_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (push_cmd),
    .pop_i (pop),
    .head_o(head_cmd),
    .stat_o(queue_stat)
  );

  ntm_back #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .SIGNAL_LENGTH(SIGNAL_LENGTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entries_in_use_i(entries_q),
    .head_valid_i    (!queue_stat.empty),
    .head_i          (head_cmd),
    .pop_o           (pop),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata)
  );

endmodule

@@ rtl/core/ntm_checker.sv @@
module ntm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ntm_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [ntm_pkg::APB_ADDR_W-1:0] paddr,
  input logic [ntm_pkg::APB_DATA_W-1:0] pwdata,
  input logic [ntm_pkg::APB_DATA_W-1:0] prdata
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input queue filled without an accepted beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite && !paddr[2]) && !paddr[2]
    |-> prdata[ntm_pkg::CFG_W-1:0] == $past(pwdata[ntm_pkg::CFG_W-1:0]))
    else $error("entry count does not read back as written");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[ntm_pkg::APB_DATA_W-1:ntm_pkg::CFG_W] == '0)
    else $error("unused read data bits are not zero");

endmodule

bind nearest_template_match ntm_checker u_ntm_checker (.*);
